FILE: hdl/mmeb_pkg.sv
`timescale 1ns / 1ps

package mmeb_pkg;

  // Default field widths; the top level takes these as parameter defaults.
  localparam int DEF_TIME_BITS  = 48;
  localparam int DEF_INDEX_BITS = 32;

  // Fixed field widths.
  localparam int VALUE_BITS   = 32;
  localparam int DIVISOR_BITS = 32;
  localparam int REQ_BITS     = 2;
  localparam int KIND_BITS    = 2;

  // Configuration port geometry: registers sit on 8-byte boundaries.
  localparam int PADDR_BITS  = 4;
  localparam int PDATA_BITS  = 64;
  localparam int REG_SEL_BIT = 3;

  localparam logic REG_START = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  localparam logic [DIVISOR_BITS-1:0] WIDTH_RESET = DIVISOR_BITS'(1000);

  // Request codes.
  localparam logic [REQ_BITS-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_GAP    = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_FINISH = 2'd2;

  // Result kinds.
  localparam logic [KIND_BITS-1:0] KIND_BUCKET = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_GAP    = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_END    = 2'd2;

  // Status of the serial divider as seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/mmeb_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend is shifted out
// of the top of a shift register while quotient bits are shifted in below.
module mmeb_divider #(
  parameter int DVD_BITS = mmeb_pkg::DEF_TIME_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [DVD_BITS-1:0]                 dividend,
  input  logic [mmeb_pkg::DIVISOR_BITS-1:0]   divisor,
  output mmeb_pkg::div_stat_t                 stat,
  output logic [DVD_BITS-1:0]                 quotient,
  output logic [mmeb_pkg::DIVISOR_BITS-1:0]   remainder
);

  localparam int DW       = mmeb_pkg::DIVISOR_BITS;
  localparam int CNT_BITS = $clog2(DVD_BITS + 1);

  logic [DVD_BITS-1:0] dq_r, dq_nxt;
  logic [DW-1:0]       rem_r, rem_nxt;
  logic [DW-1:0]       dvs_r, dvs_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  logic [DW:0]         trial;
  logic                fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_r, dq_r[DVD_BITS-1]};
    fits  = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_BITS'(DVD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = DW'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[DW-1:0];
      end
      dq_nxt  = {dq_r[DVD_BITS-2:0], fits};
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;
  assign remainder = rem_r;

endmodule

FILE: hdl/min_max_envelope_bucketer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    req_type, sample_time_ms, sample_value
// out_      output     out_valid / out_ready  result_kind, bucket_index, env_low, env_high,
//                                             fault, last_of_run
// APB       config     psel/penable, pready=1 start (0x0), bucket width (0x8)
//
// A sample inside the cached bucket window is folded in from S_CHECK; one that
// leaves it runs through S_DIV, where the bit-serial divider yields one quotient
// bit per cycle, and then S_APPLY. Gap and finish requests pass S_CHECK and S_MARK.
// Reset is synchronous and active low; all bucket state clears at once.
// A full output register stalls the controller in place until out_ready.
module min_max_envelope_bucketer #(
  parameter int TIME_BITS  = mmeb_pkg::DEF_TIME_BITS,
  parameter int INDEX_BITS = mmeb_pkg::DEF_INDEX_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mmeb_pkg::REQ_BITS-1:0]        in_req_type,
  input  logic [TIME_BITS-1:0]                 in_sample_time_ms,
  input  logic signed [mmeb_pkg::VALUE_BITS-1:0] in_sample_value,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mmeb_pkg::KIND_BITS-1:0]       out_result_kind,
  output logic [INDEX_BITS-1:0]                out_bucket_index,
  output logic signed [mmeb_pkg::VALUE_BITS-1:0] out_env_low,
  output logic signed [mmeb_pkg::VALUE_BITS-1:0] out_env_high,
  output logic                                 out_fault,
  output logic                                 out_last_of_run,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mmeb_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [mmeb_pkg::PDATA_BITS-1:0]      pwdata,
  output logic [mmeb_pkg::PDATA_BITS-1:0]      prdata,
  output logic                                 pready
);

  localparam int VB = mmeb_pkg::VALUE_BITS;
  localparam int WB = mmeb_pkg::DIVISOR_BITS;
  localparam int KB = mmeb_pkg::KIND_BITS;
  localparam int RB = mmeb_pkg::REQ_BITS;

  localparam logic [TIME_BITS-1:0]  GAP_INDEX  = TIME_BITS'({INDEX_BITS{1'b1}});
  localparam logic [TIME_BITS-1:0]  TIME_MAX   = {TIME_BITS{1'b1}};
  localparam logic [INDEX_BITS-1:0] MARK_INDEX = {INDEX_BITS{1'b1}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;

  // Configuration registers.
  logic [TIME_BITS-1:0] start_r;
  logic [WB-1:0]        bw_r;

  // Controller and bucket state.
  logic [2:0]            state_r, state_nxt;
  logic                  open_r, open_nxt;
  logic                  valid_r, valid_nxt;
  logic [TIME_BITS-1:0]  cur_idx_r, cur_idx_nxt;
  logic [TIME_BITS-1:0]  begin_r, begin_nxt;
  logic [TIME_BITS-1:0]  end_r, end_nxt;
  logic signed [VB-1:0]  min_r, min_nxt;
  logic signed [VB-1:0]  max_r, max_nxt;
  logic                  fault_r, fault_nxt;
  logic                  locked_r, locked_nxt;
  logic [WB-1:0]         series_w_r, series_w_nxt;

  // Latched request.
  logic [RB-1:0]         req_r, req_nxt;
  logic [TIME_BITS-1:0]  t_r, t_nxt;
  logic signed [VB-1:0]  v_r, v_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [KB-1:0]         out_kind_r, out_kind_nxt;
  logic [INDEX_BITS-1:0] out_idx_r, out_idx_nxt;
  logic signed [VB-1:0]  out_min_r, out_min_nxt;
  logic signed [VB-1:0]  out_max_r, out_max_nxt;
  logic                  out_fault_r, out_fault_nxt;
  logic                  out_last_r, out_last_nxt;

  // Divider hookup.
  logic                  div_start;
  logic [WB-1:0]         w_eff;
  logic [TIME_BITS-1:0]  div_q;
  logic [WB-1:0]         div_rem;
  mmeb_pkg::div_stat_t   div_stat;

  // Working values for a bucket change.
  logic                  can_load;
  logic                  in_window;
  logic                  idx_change;
  logic                  idx_in_range;
  logic                  flush_emit;
  logic                  open_after;
  logic [TIME_BITS-1:0]  begin_calc;
  logic [TIME_BITS:0]    end_sum;
  logic                  cfg_wr;

  mmeb_divider #(
    .DVD_BITS(TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (t_r - start_r),
    .divisor  (w_eff),
    .stat     (div_stat),
    .quotient (div_q),
    .remainder(div_rem)
  );

  // Configuration access; registers are decoded on the 8-byte slot bit.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[mmeb_pkg::REG_SEL_BIT])
      mmeb_pkg::REG_START: prdata = mmeb_pkg::PDATA_BITS'(start_r);
      default:             prdata = mmeb_pkg::PDATA_BITS'(bw_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      bw_r    <= mmeb_pkg::WIDTH_RESET;
    end else if (cfg_wr) begin
      if (paddr[mmeb_pkg::REG_SEL_BIT] == mmeb_pkg::REG_START) begin
        start_r <= pwdata[TIME_BITS-1:0];
      end else begin
        bw_r <= pwdata[WB-1:0];
      end
    end
  end

  // Shared decode terms.
  always_comb begin
    can_load     = !out_valid_r || out_ready;
    in_window    = valid_r && (t_r >= begin_r) && (t_r < end_r);
    idx_in_range = (cur_idx_r < GAP_INDEX);
    idx_change   = !valid_r || (div_q != cur_idx_r);
    flush_emit   = idx_change && open_r && idx_in_range;
    open_after   = idx_change ? 1'b0 : open_r;
    begin_calc   = t_r - TIME_BITS'(div_rem);
    end_sum      = {1'b0, begin_calc} + (TIME_BITS + 1)'(series_w_r);
    if (locked_r) begin
      w_eff = series_w_r;
    end else if (bw_r == '0) begin
      w_eff = WB'(1);
    end else begin
      w_eff = bw_r;
    end
  end

  // Request sequencer.
  always_comb begin
    state_nxt     = state_r;
    open_nxt      = open_r;
    valid_nxt     = valid_r;
    cur_idx_nxt   = cur_idx_r;
    begin_nxt     = begin_r;
    end_nxt       = end_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    fault_nxt     = fault_r;
    locked_nxt    = locked_r;
    series_w_nxt  = series_w_r;
    req_nxt       = req_r;
    t_nxt         = t_r;
    v_nxt         = v_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_fault_nxt = out_fault_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          t_nxt     = in_sample_time_ms;
          v_nxt     = in_sample_value;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        case (req_r)
          mmeb_pkg::REQ_SAMPLE: begin
            if (t_r < start_r) begin
              state_nxt = S_IDLE;
            end else begin
              // The first sample of a series fixes the bucket width.
              locked_nxt   = 1'b1;
              series_w_nxt = w_eff;
              if (in_window) begin
                open_nxt = 1'b1;
                if (!open_r) begin
                  min_nxt = v_r;
                  max_nxt = v_r;
                end else begin
                  if (v_r < min_r) min_nxt = v_r;
                  if (v_r > max_r) max_nxt = v_r;
                end
                state_nxt = S_IDLE;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
          end

          mmeb_pkg::REQ_GAP, mmeb_pkg::REQ_FINISH: begin
            // Flush the open bucket before the marker; an index out of range sets the fault instead.
            if (!open_r) begin
              state_nxt = S_MARK;
            end else if (!idx_in_range) begin
              fault_nxt = 1'b1;
              open_nxt  = 1'b0;
              state_nxt = S_MARK;
            end else if (can_load) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = mmeb_pkg::KIND_BUCKET;
              out_idx_nxt   = cur_idx_r[INDEX_BITS-1:0];
              out_min_nxt   = min_r;
              out_max_nxt   = max_r;
              out_fault_nxt = fault_r;
              out_last_nxt  = 1'b0;
              open_nxt      = 1'b0;
              state_nxt     = S_MARK;
            end
          end

          default: state_nxt = S_IDLE;
        endcase
      end

      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_APPLY;
        end
      end

      S_APPLY: begin
        // Commit only once the flushed bucket can be presented.
        if (!flush_emit || can_load) begin
          if (flush_emit) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = mmeb_pkg::KIND_BUCKET;
            out_idx_nxt   = cur_idx_r[INDEX_BITS-1:0];
            out_min_nxt   = min_r;
            out_max_nxt   = max_r;
            out_fault_nxt = fault_r;
            out_last_nxt  = 1'b1;
          end
          if (idx_change && open_r && !idx_in_range) begin
            fault_nxt = 1'b1;
          end
          if (idx_change) begin
            cur_idx_nxt = div_q;
            valid_nxt   = 1'b1;
            begin_nxt   = begin_calc;
            end_nxt     = end_sum[TIME_BITS] ? TIME_MAX : end_sum[TIME_BITS-1:0];
          end
          open_nxt = 1'b1;
          if (!open_after) begin
            min_nxt = v_r;
            max_nxt = v_r;
          end else begin
            if (v_r < min_r) min_nxt = v_r;
            if (v_r > max_r) max_nxt = v_r;
          end
          state_nxt = S_IDLE;
        end
      end

      S_MARK: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = '0;
          out_max_nxt   = '0;
          out_fault_nxt = fault_r;
          out_last_nxt  = 1'b1;
          valid_nxt     = 1'b0;
          cur_idx_nxt   = '0;
          begin_nxt     = '0;
          end_nxt       = '0;
          min_nxt       = '0;
          max_nxt       = '0;
          if (req_r == mmeb_pkg::REQ_GAP) begin
            out_kind_nxt = mmeb_pkg::KIND_GAP;
            out_idx_nxt  = MARK_INDEX;
          end else begin
            // End of series also drops the fault and the width lock.
            out_kind_nxt = mmeb_pkg::KIND_END;
            out_idx_nxt  = '0;
            open_nxt     = 1'b0;
            fault_nxt    = 1'b0;
            locked_nxt   = 1'b0;
            series_w_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and bucket state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= 1'b0;
      valid_r     <= 1'b0;
      cur_idx_r   <= '0;
      begin_r     <= '0;
      end_r       <= '0;
      min_r       <= '0;
      max_r       <= '0;
      fault_r     <= 1'b0;
      locked_r    <= 1'b0;
      series_w_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      valid_r     <= valid_nxt;
      cur_idx_r   <= cur_idx_nxt;
      begin_r     <= begin_nxt;
      end_r       <= end_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      fault_r     <= fault_nxt;
      locked_r    <= locked_nxt;
      series_w_r  <= series_w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    t_r         <= t_nxt;
    v_r         <= v_nxt;
    out_kind_r  <= out_kind_nxt;
    out_idx_r   <= out_idx_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
    out_fault_r <= out_fault_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_bucket_index = out_idx_r;
  assign out_env_low      = out_min_r;
  assign out_env_high     = out_max_r;
  assign out_fault        = out_fault_r;
  assign out_last_of_run  = out_last_r;

  // An open bucket always has a current index.
  a_open_has_index: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> valid_r)
    else $error("open bucket without a current index");

  // The running envelope never inverts.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (min_r <= max_r))
    else $error("bucket minimum above maximum");

  // The divider only runs while the sequencer waits for it.
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> (state_r == S_DIV))
    else $error("divider active outside the divide wait");

  // A locked series width is never zero.
  a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    locked_r |-> (series_w_r != '0))
    else $error("locked bucket width is zero");

endmodule
